FILE: hdl/obst_pkg.sv
package obst_pkg;

    localparam int MAX_KEYS_DEF   = 16;
    localparam int COST_WIDTH_DEF = 24;
    localparam int KEY_W          = 5;
    localparam int OUT_COST_W     = 24;
    localparam int PROB_W         = 16;

    // Byte address of the key_count register
    localparam logic [1:0] REG_KEY_COUNT = 2'd0;

    typedef struct packed {
        logic [4:0]  index;
        logic [15:0] key_prob;
        logic [15:0] gap_prob;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  key;
        logic [4:0]  parent;
        logic        side;
        logic [23:0] min_cost;
        logic        last_res;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // write the input pair to the probability stores
        logic base;      // write diagonal base entries for row i
        logic wcalc;     // compute and write weight for interval (i,j)
        logic rstep;     // evaluate one root candidate r
        logic rfirst;    // candidate is the first of its interval
        logic commit;    // write best cost and root of (i,j)
        logic rd_cl;     // read cost (i,r-1)
        logic rd_cr;     // read cost (r+1,j)
        logic rd_w;      // read weight (i,j-1) and p_j, q_j
        logic get_mc;    // latch cost (1,n)
        logic [4:0] i;
        logic [4:0] j;
        logic [4:0] r;
    } dp_cmd_t;

endpackage

FILE: hdl/obst_ram.sv
module obst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/obst_datapath.sv
module obst_datapath import obst_pkg::*; #(
    parameter int MAX_KEYS   = MAX_KEYS_DEF,
    parameter int COST_WIDTH = COST_WIDTH_DEF
) (
    input  logic                  clk,
    input  dp_cmd_t               cmd,
    input  in_item_t              item,
    output logic [KEY_W-1:0]      root_rd,
    output logic [OUT_COST_W-1:0] min_cost
);

    localparam int SD      = MAX_KEYS + 1;
    localparam int SA      = $clog2(SD);
    localparam int TD      = (MAX_KEYS + 2) * (MAX_KEYS + 1);
    localparam int TA      = $clog2(TD);
    localparam logic [COST_WIDTH-1:0] CMAX = '1;

    logic [PROB_W-1:0] p_rd, q_rd;
    logic [COST_WIDTH-1:0] c_rd, w_rd;
    logic [COST_WIDTH-1:0] cl_reg, cl_next;
    logic [COST_WIDTH-1:0] w_reg, w_next;
    logic [COST_WIDTH-1:0] best_reg, best_next;
    logic [KEY_W-1:0] broot_reg, broot_next;
    logic [COST_WIDTH-1:0] mc_reg, mc_next;
    logic [SA-1:0] s_raddr;
    logic [TA-1:0] c_raddr, c_waddr, w_raddr, w_waddr;
    logic [COST_WIDTH-1:0] c_wdata, w_wdata;
    logic c_we, w_we, r_we;
    logic [COST_WIDTH:0] s1, s2, s3;
    logic [COST_WIDTH-1:0] t1, wsum, cand;
    logic [KEY_W-1:0] r_wdata;
    logic [TA-1:0] r_raddr;

    function automatic logic [TA-1:0] taddr(input logic [4:0] a, input logic [4:0] b);
        logic [TA+5:0] v;
        v = (TA+6)'(a) * (TA+6)'(MAX_KEYS + 1) + (TA+6)'(b);
        return v[TA-1:0];
    endfunction

    function automatic logic [COST_WIDTH-1:0] sat(input logic [COST_WIDTH:0] s);
        return s[COST_WIDTH] ? CMAX : s[COST_WIDTH-1:0];
    endfunction

    // Probability stores share one read address: j for the weight step, else i
    always_comb
    begin
        s_raddr = cmd.rd_w ? SA'(cmd.j) : SA'(cmd.i);
    end

    obst_ram #(.WIDTH(PROB_W), .DEPTH(SD)) u_pstore (
        .clk(clk), .we(cmd.load), .waddr(item.index[SA-1:0]), .wdata(item.key_prob),
        .raddr(s_raddr), .rdata(p_rd));
    obst_ram #(.WIDTH(PROB_W), .DEPTH(SD)) u_qstore (
        .clk(clk), .we(cmd.load), .waddr(item.index[SA-1:0]), .wdata(item.gap_prob),
        .raddr(s_raddr), .rdata(q_rd));

    // Saturating sums
    always_comb
    begin
        s1   = {1'b0, w_rd} + (COST_WIDTH+1)'(p_rd);
        wsum = sat(s1);
        s2   = {1'b0, wsum} + (COST_WIDTH+1)'(q_rd);
        s3   = {1'b0, cl_reg} + {1'b0, c_rd};
        t1   = sat(s3);
        cand = sat({1'b0, t1} + {1'b0, w_reg});
    end

    // Table write ports
    always_comb
    begin
        c_we    = cmd.base || cmd.commit;
        w_we    = cmd.base || cmd.wcalc;
        r_we    = cmd.commit;
        c_waddr = taddr(cmd.i, cmd.j);
        w_waddr = taddr(cmd.i, cmd.j);
        c_wdata = cmd.base ? COST_WIDTH'(q_rd) : best_reg;
        w_wdata = cmd.base ? COST_WIDTH'(q_rd) : sat(s2);
        r_wdata = broot_reg;
        priority if (cmd.rd_cl)
        begin
            c_raddr = taddr(cmd.i, cmd.r - 5'd1);
        end
        else if (cmd.rd_cr)
        begin
            c_raddr = taddr(cmd.r + 5'd1, cmd.j);
        end
        else
        begin
            c_raddr = taddr(5'd1, cmd.j);
        end
        w_raddr = cmd.rd_w ? taddr(cmd.i, cmd.j - 5'd1) : taddr(cmd.i, cmd.j);
        r_raddr = taddr(cmd.i, cmd.j);
    end

    obst_ram #(.WIDTH(COST_WIDTH), .DEPTH(TD)) u_cost (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rd));
    obst_ram #(.WIDTH(COST_WIDTH), .DEPTH(TD)) u_weight (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rd));
    obst_ram #(.WIDTH(KEY_W), .DEPTH(TD)) u_root (
        .clk(clk), .we(r_we), .waddr(taddr(cmd.i, cmd.j)), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(root_rd));

    // Operand and best-candidate registers
    always_comb
    begin
        cl_next    = cmd.rd_cr ? c_rd : cl_reg;
        w_next     = cmd.wcalc ? sat(s2) : w_reg;
        best_next  = best_reg;
        broot_next = broot_reg;
        if (cmd.rstep && (cmd.rfirst || cand < best_reg))
        begin
            best_next  = cand;
            broot_next = cmd.r;
        end
        mc_next = cmd.get_mc ? c_rd : mc_reg;
    end

    always_ff @(posedge clk)
    begin
        cl_reg    <= cl_next;
        w_reg     <= w_next;
        best_reg  <= best_next;
        broot_reg <= broot_next;
        mc_reg    <= mc_next;
    end

    generate
        if (COST_WIDTH > OUT_COST_W)
        begin : g_sat
            assign min_cost = (|mc_reg[COST_WIDTH-1:OUT_COST_W]) ? '1
                                                               : mc_reg[OUT_COST_W-1:0];
        end
        else
        begin : g_ext
            assign min_cost = OUT_COST_W'(mc_reg);
        end
    endgenerate

endmodule

FILE: hdl/obst_ctrl.sv
module obst_ctrl import obst_pkg::*; #(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [4:0]       key_count,
    input  logic             in_valid,
    input  in_item_t         in_item,
    output logic             in_stall,
    output dp_cmd_t          cmd,
    input  logic [KEY_W-1:0] root_rd,
    output logic             out_valid,
    output logic [4:0]       out_key,
    output logic [4:0]       out_parent,
    output logic             out_side,
    output logic             out_last,
    input  logic             out_stall
);

    localparam int SP_W = $clog2(MAX_KEYS + 3);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BRD   = 4'd1;
    localparam logic [3:0] S_BWR   = 4'd2;
    localparam logic [3:0] S_WRD   = 4'd3;
    localparam logic [3:0] S_WCALC = 4'd4;
    localparam logic [3:0] S_CL    = 4'd5;
    localparam logic [3:0] S_CR    = 4'd6;
    localparam logic [3:0] S_CAND  = 4'd7;
    localparam logic [3:0] S_COMM  = 4'd8;
    localparam logic [3:0] S_MC    = 4'd9;
    localparam logic [3:0] S_MCW   = 4'd10;
    localparam logic [3:0] S_POP   = 4'd11;
    localparam logic [3:0] S_RRD   = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [4:0] n_reg, n_next, i_reg, i_next, j_reg, j_next, r_reg, r_next, l_reg, l_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [4:0] stk_lo [MAX_KEYS + 2];
    logic [4:0] stk_hi [MAX_KEYS + 2];
    logic [4:0] stk_par [MAX_KEYS + 2];
    logic       stk_side [MAX_KEYS + 2];
    logic [4:0] lo_reg, lo_next, hi_reg, hi_next, par_reg, par_next;
    logic       side_reg, side_next;
    logic [4:0] key_reg, key_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       push, push_root;
    logic [4:0] eff_n;
    logic       acc;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign acc       = in_valid && !in_stall;

    always_comb
    begin
        eff_n = key_count;
        if (key_count == 5'd0)
        begin
            eff_n = 5'd1;
        end
        else if (32'(key_count) > MAX_KEYS)
        begin
            eff_n = 5'(MAX_KEYS);
        end
    end

    // Sequence the load, table fill and preorder walk
    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg; i_next = i_reg; j_next = j_reg; r_next = r_reg; l_next = l_reg;
        sp_next = sp_reg;
        lo_next = lo_reg; hi_next = hi_reg; par_next = par_reg; side_next = side_reg;
        key_next = key_reg;
        cnt_next = cnt_reg;
        push = 1'b0; push_root = 1'b0;
        cmd = '0;
        cmd.i = i_reg; cmd.j = j_reg; cmd.r = r_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = acc && (32'(in_item.index) <= MAX_KEYS);
                if (acc && in_item.last)
                begin
                    n_next = eff_n;
                    i_next = 5'd1;
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                // q(i-1) read at address i-1
                cmd.i = i_reg - 5'd1;
                state_next = S_BWR;
            end
            S_BWR:
            begin
                cmd.base = 1'b1;
                cmd.j = i_reg - 5'd1;
                if (i_reg == n_reg + 5'd1)
                begin
                    l_next = 5'd1; i_next = 5'd1; j_next = 5'd1;
                    state_next = S_WRD;
                end
                else
                begin
                    i_next = i_reg + 5'd1;
                    state_next = S_BRD;
                end
            end
            S_WRD:
            begin
                // weight (i,j-1) and p_j, q_j
                cmd.rd_w = 1'b1;
                state_next = S_WCALC;
                r_next = i_reg;
            end
            S_WCALC:
            begin
                cmd.wcalc = 1'b1;
                state_next = S_CL;
            end
            S_CL:
            begin
                cmd.rd_cl = 1'b1;
                state_next = S_CR;
            end
            S_CR:
            begin
                cmd.rd_cr = 1'b1;
                state_next = S_CAND;
            end
            S_CAND:
            begin
                cmd.rstep = 1'b1;
                cmd.rfirst = (r_reg == i_reg);
                if (r_reg == j_reg)
                begin
                    state_next = S_COMM;
                end
                else
                begin
                    r_next = r_reg + 5'd1;
                    state_next = S_CL;
                end
            end
            S_COMM:
            begin
                cmd.commit = 1'b1;
                if (j_reg == n_reg)
                begin
                    if (l_reg == n_reg)
                    begin
                        j_next = n_reg;
                        state_next = S_MC;
                    end
                    else
                    begin
                        l_next = l_reg + 5'd1;
                        i_next = 5'd1;
                        j_next = l_reg + 5'd1;
                        state_next = S_WRD;
                    end
                end
                else
                begin
                    i_next = i_reg + 5'd1;
                    j_next = j_reg + 5'd1;
                    state_next = S_WRD;
                end
            end
            S_MC:
            begin
                cmd.j = n_reg;
                state_next = S_MCW;
            end
            S_MCW:
            begin
                cmd.get_mc = 1'b1;
                push_root = 1'b1;
                sp_next = SP_W'(1);
                cnt_next = 5'd0;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sp_next = sp_reg - SP_W'(1);
                    lo_next = stk_lo[sp_reg - SP_W'(1)];
                    hi_next = stk_hi[sp_reg - SP_W'(1)];
                    par_next = stk_par[sp_reg - SP_W'(1)];
                    side_next = stk_side[sp_reg - SP_W'(1)];
                    state_next = (stk_lo[sp_reg - SP_W'(1)] > stk_hi[sp_reg - SP_W'(1)])
                                 ? S_POP : S_RRD;
                end
            end
            S_RRD:
            begin
                cmd.i = lo_reg; cmd.j = hi_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                key_next = (root_rd < lo_reg || root_rd > hi_reg) ? lo_reg : root_rd;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    cnt_next = cnt_reg + 5'd1;
                    push = 32'(sp_reg) + 2 <= MAX_KEYS + 2;
                    if (push)
                    begin
                        sp_next = sp_reg + SP_W'(2);
                    end
                    state_next = S_POP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next; i_reg <= i_next; j_reg <= j_next; r_reg <= r_next; l_reg <= l_next;
        lo_reg <= lo_next; hi_reg <= hi_next; par_reg <= par_next; side_reg <= side_next;
        key_reg <= key_next;
        cnt_reg <= cnt_next;
        if (push_root)
        begin
            stk_lo[0] <= 5'd1; stk_hi[0] <= n_reg; stk_par[0] <= 5'd0; stk_side[0] <= 1'b0;
        end
        if (push)
        begin
            stk_lo[sp_reg] <= key_reg + 5'd1;
            stk_hi[sp_reg] <= hi_reg;
            stk_par[sp_reg] <= key_reg;
            stk_side[sp_reg] <= 1'b1;
            stk_lo[sp_reg + SP_W'(1)] <= lo_reg;
            stk_hi[sp_reg + SP_W'(1)] <= key_reg - 5'd1;
            stk_par[sp_reg + SP_W'(1)] <= key_reg;
            stk_side[sp_reg + SP_W'(1)] <= 1'b0;
        end
    end

    assign out_key    = key_reg;
    assign out_parent = par_reg;
    assign out_side   = side_reg;
    // Final node: every key is emitted once, so the n-th transfer is the last
    assign out_last   = (cnt_reg + 5'd1 == n_reg);

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken during walk");
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= MAX_KEYS + 2) else $error("walk stack overflow");
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_key >= 5'd1 && out_key <= n_reg)) else $error("key out of range");
`endif

endmodule

FILE: hdl/optimal_bst_dp.sv
// Optimal binary search tree solver. Load items are taken one per cycle; the item
// marked last starts the table fill: first the base entries, then, per interval,
// the weight and each root candidate in turn, then a fetch of the total cost,
// followed by a preorder walk that emits each node and skips empty subtrees,
// held by any output stall. The input is stalled until the walk is done. Every
// result carries the saturated cost.
module optimal_bst_dp import obst_pkg::*; #(
    parameter int MAX_KEYS   = MAX_KEYS_DEF,
    parameter int COST_WIDTH = COST_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    logic [4:0] key_count_reg;
    dp_cmd_t cmd;
    logic [KEY_W-1:0] root_rd;
    logic [OUT_COST_W-1:0] min_cost;
    logic [4:0] k, p;
    logic s, l;

    assign pready = 1'b1;

    // Register write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= 5'd1;
        end
        else if (psel && penable && pwrite && paddr == REG_KEY_COUNT)
        begin
            key_count_reg <= pwdata[4:0];
        end
    end

    assign prdata = (paddr == REG_KEY_COUNT) ? {27'd0, key_count_reg} : 32'd0;

    obst_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .key_count(key_count_reg),
        .in_valid(in_valid), .in_item(in_data), .in_stall(in_stall),
        .cmd(cmd), .root_rd(root_rd),
        .out_valid(out_valid), .out_key(k), .out_parent(p), .out_side(s),
        .out_last(l), .out_stall(out_stall));

    obst_datapath #(.MAX_KEYS(MAX_KEYS), .COST_WIDTH(COST_WIDTH)) u_dp (
        .clk(clk), .cmd(cmd), .item(in_data),
        .root_rd(root_rd), .min_cost(min_cost));

    assign out_data = '{key: k, parent: p, side: s, min_cost: min_cost, last_res: l};

endmodule
